/* design/csq_pkg.sv */
`default_nettype none

package csq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int THREAD_ID_BITS = 8;
    localparam int MAX_RESULTS    = 16;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    localparam logic [1:0] KIND_WAIT       = 2'd0;
    localparam logic [1:0] KIND_SIGNAL     = 2'd1;
    localparam logic [1:0] KIND_SIGNAL_ALL = 2'd2;
    localparam logic [1:0] KIND_UNUSED     = 2'd3;

    localparam logic [2:0] STAT_GRANTED    = 3'd0;
    localparam logic [2:0] STAT_QUEUED     = 3'd1;
    localparam logic [2:0] STAT_FULL       = 3'd2;
    localparam logic [2:0] STAT_NONE       = 3'd3;
    localparam logic [2:0] STAT_RELEASED   = 3'd4;
    localparam logic [2:0] STAT_BULK       = 3'd5;
    localparam logic [2:0] STAT_BULK_EMPTY = 3'd6;

    localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;

    typedef logic [THREAD_ID_BITS-1:0] tid_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } queue_ctrl_t;

endpackage

`default_nettype wire

/* design/csq_cell.sv */
`default_nettype none

module csq_cell (
    input  wire logic          clk,
    input  wire logic          shift,
    input  wire logic          load,
    input  wire csq_pkg::tid_t load_data,
    input  wire csq_pkg::tid_t neighbor_data,
    output csq_pkg::tid_t      data
);
    import csq_pkg::*;

    tid_t data_reg;
    tid_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (load)
        begin
            data_next = load_data;
        end
        else if (shift)
        begin
            data_next = neighbor_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* design/csq_queue.sv */
`default_nettype none

module csq_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire csq_pkg::queue_ctrl_t     ctrl,
    input  wire csq_pkg::tid_t            push_data,
    output csq_pkg::tid_t                 head_data,
    output logic [csq_pkg::OCC_W-1:0]     occupancy,
    output logic                          full
);
    import csq_pkg::*;

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    tid_t             cell_q [QUEUE_DEPTH];

    // The head sits in cell 0; a pop moves every cell one place toward the head.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        tid_t nbr;
        if (i == QUEUE_DEPTH - 1)
        begin : g_end
            assign nbr = cell_q[i];
        end
        else
        begin : g_mid
            assign nbr = cell_q[i+1];
        end

        csq_cell u_cell (
            .clk           (clk),
            .shift         (ctrl.pop),
            .load          (ctrl.push && (occ_reg == OCC_W'(i))),
            .load_data     (push_data),
            .neighbor_data (nbr),
            .data          (cell_q[i])
        );
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (ctrl.clear)
        begin
            occ_next = '0;
        end
        else if (ctrl.push)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (ctrl.pop)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign head_data = cell_q[0];
    assign occupancy = occ_reg;
    assign full      = (occ_reg == OCC_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

/* design/counting_semaphore_wait_queue.sv */
`default_nettype none

// Counting semaphore with a FIFO queue of blocked thread ids. A request is taken
// when start is high and busy and cfg_wr_en are low. Wait and signal requests give
// one result, presented on the result ports with done high for exactly one cycle,
// in the cycle after the request; the next request can be taken in that same
// cycle. Signal-all on an empty queue behaves the same way. Signal-all with queued
// threads releases one thread per cycle, up to the queue depth, because the queue
// is a row of cells that shifts one entry toward the head per cycle: busy is high
// from the cycle after the request while the threads are popped, each result is
// registered from the queue head in the bulk state, and the next request can be
// taken in the cycle the last result is shown. last marks the final result of each
// request. The receiver cannot stall: every result must be taken in the cycle it is
// shown. Writing cfg_wr_data with cfg_wr_en loads the count and empties the queue;
// do so only while idle.
module counting_semaphore_wait_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic signed [15:0] cfg_wr_data,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         kind,
    input  wire logic [7:0]         thread_id,
    output logic                    done,
    output logic [2:0]              status,
    output logic [7:0]              thread_out,
    output logic signed [15:0]      count_value,
    output logic                    last
);
    import csq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BULK = 1'b1;

    logic               state_reg, state_next;
    logic signed [15:0] count_reg, count_next;
    logic [RES_W-1:0]   n_reg, n_next;

    logic               done_reg, done_next;
    logic [2:0]         status_reg, status_next;
    logic [7:0]         thread_reg, thread_next;
    logic signed [15:0] cnt_out_reg, cnt_out_next;
    logic               last_reg, last_next;

    queue_ctrl_t        qctrl;
    tid_t               head_data;
    tid_t               push_data;
    logic [OCC_W-1:0]   occupancy;
    logic               full;
    logic               accept;
    logic signed [15:0] count_inc;
    logic               bulk_fin;

    assign push_data = thread_id[THREAD_ID_BITS-1:0];

    csq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (qctrl),
        .push_data (push_data),
        .head_data (head_data),
        .occupancy (occupancy),
        .full      (full)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'sd1;
    assign bulk_fin  = (occupancy == OCC_W'(1)) || (n_reg == RES_W'(MAX_RESULTS - 1));

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        n_next       = n_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        thread_next  = thread_reg;
        cnt_out_next = cnt_out_reg;
        last_next    = last_reg;
        qctrl        = '0;

        if (state_reg == S_BULK)
        begin
            qctrl.pop    = 1'b1;
            done_next    = 1'b1;
            status_next  = STAT_BULK;
            thread_next  = 8'(head_data);
            cnt_out_next = '0;
            last_next    = bulk_fin;
            n_next       = n_reg + RES_W'(1);
            if (bulk_fin)
            begin
                state_next = S_IDLE;
            end
        end
        else if (cfg_wr_en)
        begin
            qctrl.clear = 1'b1;
            count_next  = cfg_wr_data;
        end
        else if (accept)
        begin
            unique case (kind)
                KIND_WAIT:
                begin
                    done_next   = 1'b1;
                    last_next   = 1'b1;
                    thread_next = 8'(push_data);
                    if (count_reg > 16'sd0)
                    begin
                        count_next  = count_reg - 16'sd1;
                        status_next = STAT_GRANTED;
                    end
                    else if (!full)
                    begin
                        qctrl.push  = 1'b1;
                        status_next = STAT_QUEUED;
                    end
                    else
                    begin
                        status_next = STAT_FULL;
                    end
                    cnt_out_next = count_next;
                end
                KIND_SIGNAL:
                begin
                    done_next = 1'b1;
                    last_next = 1'b1;
                    if ((count_inc > 16'sd0) && (occupancy != '0))
                    begin
                        // The released waiter's own decrement is folded in here.
                        qctrl.pop   = 1'b1;
                        count_next  = count_inc - 16'sd1;
                        status_next = STAT_RELEASED;
                        thread_next = 8'(head_data);
                    end
                    else
                    begin
                        count_next  = count_inc;
                        status_next = STAT_NONE;
                        thread_next = '0;
                    end
                    cnt_out_next = count_next;
                end
                KIND_SIGNAL_ALL:
                begin
                    count_next = '0;
                    n_next     = '0;
                    if (occupancy == '0)
                    begin
                        done_next    = 1'b1;
                        last_next    = 1'b1;
                        status_next  = STAT_BULK_EMPTY;
                        thread_next  = '0;
                        cnt_out_next = '0;
                    end
                    else
                    begin
                        state_next = S_BULK;
                    end
                end
                KIND_UNUSED:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            n_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        thread_reg  <= thread_next;
        cnt_out_reg <= cnt_out_next;
        last_reg    <= last_next;
    end

    assign busy        = (state_reg == S_BULK);
    assign done        = done_reg;
    assign status      = status_reg;
    assign thread_out  = thread_reg;
    assign count_value = cnt_out_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_bulk_has_waiter: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BULK) |-> (occupancy != '0))
        else $error("bulk release with an empty queue");

    a_no_push_and_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(qctrl.push && qctrl.pop))
        else $error("queue pushed and popped in the same cycle");

    a_bulk_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_BULK)) |-> ((count_value == 16'sd0) && (count_reg == 16'sd0)))
        else $error("bulk release with a nonzero count");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |=> done)
        else $error("result burst ended without last");
`endif

endmodule

`default_nettype wire

/* verif/counting_semaphore_wait_queue_test.sv */
`default_nettype none

module counting_semaphore_wait_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import csq_pkg::*;

    localparam int REQUEST_SLOTS = 1024;
    localparam int RESULT_SLOTS  = 64;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] tid;
    } sem_request_t;

    typedef struct {
        logic [2:0]         status;
        logic [7:0]         tid;
        logic signed [15:0] count;
        logic               last;
    } sem_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic signed [15:0] cfg_wr_data = '0;
    logic               start = 1'b0;
    logic [1:0]         kind = KIND_WAIT;
    logic [7:0]         thread_id = '0;
    logic               busy;
    logic               done;
    logic [2:0]         status;
    logic [7:0]         thread_out;
    logic signed [15:0] count_value;
    logic               last;

    // Predicted semaphore state; the waiters form a ring.
    logic signed [15:0] sem_count;
    tid_t               waiters[QUEUE_DEPTH];
    int                 wait_head = 0;
    int                 wait_count = 0;

    // Pending requests and expected results, each kept as a ring.
    sem_request_t       request_q[REQUEST_SLOTS];
    int                 req_wr = 0;
    int                 req_rd = 0;
    sem_result_t        pending_results[RESULT_SLOTS];
    int                 res_wr = 0;
    int                 res_rd = 0;

    sem_request_t       issued;
    sem_result_t        want;
    int                 failures = 0;
    int                 burst_left = 0;
    int                 gap_left = 0;
    int                 max_gap = 3;

    counting_semaphore_wait_queue u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .thread_id   (thread_id),
        .done        (done),
        .status      (status),
        .thread_out  (thread_out),
        .count_value (count_value),
        .last        (last)
    );

    always #5 clk = ~clk;

    function void post_result(input logic [2:0] st, input logic [7:0] id,
                              input logic signed [15:0] cnt, input logic fin);
        sem_result_t r;
        r.status = st;
        r.tid    = id;
        r.count  = cnt;
        r.last   = fin;
        pending_results[res_wr % RESULT_SLOTS] = r;
        res_wr++;
    endfunction

    function void add_waiter(input tid_t id);
        waiters[(wait_head + wait_count) % QUEUE_DEPTH] = id;
        wait_count++;
    endfunction

    function tid_t take_waiter();
        tid_t id;
        id = waiters[wait_head];
        wait_head = (wait_head + 1) % QUEUE_DEPTH;
        wait_count--;
        return id;
    endfunction

    function void apply_request(input logic [1:0] op, input tid_t id);
        tid_t head;
        int   n;
        n = 0;
        case (op)
            KIND_WAIT:
            begin
                if (sem_count > 0)
                begin
                    sem_count = sem_count - 16'sd1;
                    post_result(STAT_GRANTED, id, sem_count, 1'b1);
                end
                else if (wait_count < QUEUE_DEPTH)
                begin
                    add_waiter(id);
                    post_result(STAT_QUEUED, id, sem_count, 1'b1);
                end
                else
                begin
                    post_result(STAT_FULL, id, sem_count, 1'b1);
                end
            end
            KIND_SIGNAL:
            begin
                if (sem_count != COUNT_MAX)
                    sem_count = sem_count + 16'sd1;
                // The released waiter's own decrement is folded in here.
                if (sem_count > 0 && wait_count > 0)
                begin
                    head = take_waiter();
                    sem_count = sem_count - 16'sd1;
                    post_result(STAT_RELEASED, head, sem_count, 1'b1);
                end
                else
                begin
                    post_result(STAT_NONE, 8'd0, sem_count, 1'b1);
                end
            end
            KIND_SIGNAL_ALL:
            begin
                sem_count = '0;
                if (wait_count == 0)
                begin
                    post_result(STAT_BULK_EMPTY, 8'd0, 16'sd0, 1'b1);
                end
                else
                begin
                    while (wait_count > 0 && n < MAX_RESULTS)
                    begin
                        head = take_waiter();
                        post_result(STAT_BULK, head, 16'sd0,
                                    wait_count == 0 || n + 1 == MAX_RESULTS);
                        n++;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            kind      <= KIND_WAIT;
            thread_id <= '0;
        end
        else
        begin
            if (start && !busy)
                apply_request(kind, thread_id);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (req_wr != req_rd)
                begin
                    issued = request_q[req_rd % REQUEST_SLOTS];
                    req_rd++;
                    start     <= 1'b1;
                    kind      <= issued.op;
                    thread_id <= issued.tid;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 24);
                    burst_left--;
                    if (burst_left == 0 && max_gap > 0)
                        gap_left = $urandom_range(0, max_gap);
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (res_wr == res_rd)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: status %0d thread %0d count %0d last %0d",
                             status, thread_out, count_value, last);
            end
            else
            begin
                want = pending_results[res_rd % RESULT_SLOTS];
                res_rd++;
                if (status !== want.status || thread_out !== want.tid ||
                    count_value !== want.count || last !== want.last)
                begin
                    failures++;
                    if (failures <= 10)
                        $display({"mismatch: expected status %0d thread %0d count %0d ",
                                  "last %0d, got status %0d thread %0d count %0d last %0d"},
                                 want.status, want.tid, want.count, want.last,
                                 status, thread_out, count_value, last);
                end
            end
        end
    end

    task automatic queue_request(input logic [1:0] op, input logic [7:0] id);
        sem_request_t r;
        r.op  = op;
        r.tid = id;
        request_q[req_wr % REQUEST_SLOTS] = r;
        req_wr++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_wr != req_rd || start || busy || res_wr != res_rd);
    endtask

    task automatic write_initial_count(input logic signed [15:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sem_count = value;
        wait_head = 0;
        wait_count = 0;
    endtask

    initial
    begin
        logic signed [15:0] phase_counts[1:8];
        int                 remaining;
        int                 mode;
        int                 run;
        int                 op;
        int                 p;
        int                 i;

        phase_counts = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd2,
                         16'sh7FFE, -16'sd3, 16'sd1, 16'sd0};
        phase_counts[8] = 16'($urandom_range(0, 12)) - 16'sd5;
        sem_count = '0;
        wait_head = 0;
        wait_count = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening, starting from a count of zero.
        queue_request(KIND_WAIT, 8'h00);
        queue_request(KIND_WAIT, 8'hFF);
        queue_request(KIND_SIGNAL, 8'h3C);
        queue_request(KIND_SIGNAL_ALL, 8'h00);
        queue_request(KIND_SIGNAL_ALL, 8'hFF);
        queue_request(KIND_SIGNAL, 8'h00);
        queue_request(KIND_WAIT, 8'hA5);
        queue_request(KIND_UNUSED, 8'h5A);
        // Fill the queue to the brim, one refused, then release all in one go.
        for (i = 0; i < QUEUE_DEPTH; i++)
            queue_request(KIND_WAIT, 8'h10 + 8'(i));
        queue_request(KIND_WAIT, 8'hEE);
        queue_request(KIND_SIGNAL_ALL, 8'h77);

        for (p = 0; p <= 8; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                repeat (4) @(posedge clk);
                write_initial_count(phase_counts[p]);
                max_gap = (p % 3 == 2) ? 0 : $urandom_range(1, 6);
                @(negedge clk);
                // An early signal checks saturation when the count starts at the top.
                queue_request(KIND_SIGNAL, 8'($urandom_range(0, 255)));
            end
            remaining = (p == 0) ? 20 : 38;
            while (remaining > 0)
            begin
                mode = $urandom_range(0, 9);
                if (mode < 3)
                begin
                    run = $urandom_range(1, 20);
                    if (run > remaining)
                        run = remaining;
                    for (i = 0; i < run; i++)
                        queue_request(KIND_WAIT, 8'($urandom_range(0, 255)));
                    remaining -= run;
                end
                else if (mode < 6)
                begin
                    run = $urandom_range(1, 20);
                    if (run > remaining)
                        run = remaining;
                    for (i = 0; i < run; i++)
                        queue_request(KIND_SIGNAL, 8'($urandom_range(0, 255)));
                    remaining -= run;
                end
                else if (mode < 8)
                begin
                    queue_request(KIND_SIGNAL_ALL, 8'($urandom_range(0, 255)));
                    remaining--;
                end
                else
                begin
                    op = $urandom_range(0, 3);
                    queue_request(2'(op), 8'($urandom_range(0, 255)));
                    if (op != KIND_UNUSED)
                        remaining--;
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (failures == 0 && res_wr == res_rd)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* counting_semaphore_wait_queue.f */
design/csq_pkg.sv
design/csq_cell.sv
design/csq_queue.sv
design/counting_semaphore_wait_queue.sv
verif/counting_semaphore_wait_queue_test.sv
